@@ rtl/ocr_pkg.sv @@
// Shared types and constants of the online covariance regression block.
// Command and status structs between controller and datapath, codes, widths.
// No dependencies.
package ocr_pkg;

    localparam int RESULT_CAP = 32;
    localparam int COUNT_W    = 24;
    localparam int VALUE_W    = 16;
    localparam int STAT_W     = 32;
    localparam int COEF_W     = 24;
    localparam int POS_W      = 5;
    localparam int INDEX_W    = 5;
    localparam int PCNT_W     = 6;
    localparam int ACNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int DIVD_W     = 64;
    localparam int DIVS_W     = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_PERCEPT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT  = 1'b1;

    localparam logic [PCNT_W-1:0] PCNT_RESET = 6'd32;
    localparam logic [ACNT_W-1:0] ACNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        FUNC_WR_PERCEPT,
        FUNC_WR_ACTION,
        FUNC_Q_ROW,
        FUNC_Q_COL
    } func_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR,
        DP_WR,
        DP_CNT,
        DP_MDELTA,
        DP_MDIV,
        DP_MWR,
        DP_MUL1,
        DP_MUL2,
        DP_DIV1,
        DP_SUB,
        DP_DIV2,
        DP_SWR,
        DP_QDIV,
        DP_QOUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic               is_action;
        logic               is_var;
        logic               last;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_busy;
        logic var_zero;
    } dp_sts_t;

endpackage

@@ rtl/ocr_div.sv @@
// Shared iterative signed divider, one quotient bit per cycle, truncating.
// Depends on ocr_pkg for operand widths.
module ocr_div
    import ocr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIVD_W-1:0] dividend,
    input  logic signed [DIVS_W-1:0] divisor,
    output logic                     done,
    output logic signed [DIVD_W-1:0] quotient
);

    localparam int CW = $clog2(DIVD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic              neg_reg;
    logic [DIVD_W-1:0] num_reg;
    logic [DIVS_W-1:0] dmag_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVD_W-1:0] quot_reg;

    logic [DIVS_W:0]   rem_shift;
    logic              ge;
    logic [DIVS_W-1:0] rem_next;
    logic [DIVD_W-1:0] num_next;

    always_comb begin
        rem_shift = {rem_reg, num_reg[DIVD_W-1]};
        ge        = rem_shift >= {1'b0, dmag_reg};
        rem_next  = ge ? DIVS_W'(rem_shift - {1'b0, dmag_reg}) : rem_shift[DIVS_W-1:0];
        num_next  = {num_reg[DIVD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIVD_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= dividend[DIVD_W-1] ? DIVD_W'(-dividend) : dividend;
            dmag_reg <= divisor[DIVS_W-1] ? DIVS_W'(-divisor) : divisor;
            rem_reg  <= '0;
            neg_reg  <= dividend[DIVD_W-1] ^ divisor[DIVS_W-1];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            if (cnt_reg == '0) begin
                quot_reg <= neg_reg ? DIVD_W'(-num_next) : num_next;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("divider done held longer than one cycle");

endmodule

@@ rtl/ocr_datapath.sv @@
// Datapath: sample and statistic storage, covariance memory, multipliers,
// shared divider and the result register. Depends on ocr_pkg and ocr_div.
module ocr_datapath
    import ocr_pkg::*;
#(
    parameter int MAX_PERCEPTS = 32,
    parameter int MAX_ACTIONS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    input  logic [(MAX_PERCEPTS > 1 ? $clog2(MAX_PERCEPTS) : 1)-1:0] p_idx,
    input  logic [(MAX_ACTIONS > 1 ? $clog2(MAX_ACTIONS) : 1)-1:0]   a_idx,
    output dp_sts_t             sts,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [COEF_W-1:0]   m_coef,
    output logic [POS_W-1:0]    m_pos,
    output logic                m_last
);

    localparam int CD = MAX_PERCEPTS * MAX_ACTIONS;
    localparam int CW = CD > 1 ? $clog2(CD) : 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    function automatic logic [STAT_W-1:0] sat32(input logic [STAT_W+32:0] v);
        if (&v[STAT_W+32:STAT_W-1] || ~|v[STAT_W+32:STAT_W-1]) begin
            return v[STAT_W-1:0];
        end
        return v[STAT_W+32] ? {1'b1, {(STAT_W-1){1'b0}}} : {1'b0, {(STAT_W-1){1'b1}}};
    endfunction

    function automatic logic [COEF_W-1:0] sat24(input logic [DIVD_W-1:0] v);
        if (&v[DIVD_W-1:COEF_W-1] || ~|v[DIVD_W-1:COEF_W-1]) begin
            return v[COEF_W-1:0];
        end
        return v[DIVD_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    endfunction

    logic [VALUE_W-1:0] p_samp_reg [MAX_PERCEPTS];
    logic [VALUE_W-1:0] a_samp_reg [MAX_ACTIONS];
    logic [STAT_W-1:0]  p_mean_reg [MAX_PERCEPTS];
    logic [STAT_W-1:0]  a_mean_reg [MAX_ACTIONS];
    logic [STAT_W-1:0]  p_var_reg  [MAX_PERCEPTS];
    logic signed [30:0] dx_reg     [MAX_PERCEPTS];
    logic signed [30:0] dy_reg     [MAX_ACTIONS];
    logic [STAT_W-1:0]  cov_mem    [CD];

    logic [COUNT_W-1:0] n_reg;
    logic [COUNT_W-1:0] nm1_reg;
    logic [DIVD_W-1:0]  acc_reg;
    logic [STAT_W-1:0]  old_reg;
    logic signed [61:0] prod_reg;
    logic signed [60:0] mul2_reg;
    logic [STAT_W-1:0]  rdata_reg;
    logic               m_tvalid_reg;
    logic [COEF_W-1:0]  coef_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               last_reg;

    logic [CW-1:0]             addr;
    logic [VALUE_W-1:0]        x_sel;
    logic [STAT_W-1:0]         mean_sel;
    logic [STAT_W-1:0]         var_sel;
    logic [32:0]               d_next;
    logic signed [30:0]        opa;
    logic signed [30:0]        opb;
    logic signed [61:0]        prod_next;
    logic signed [35:0]        p36;
    logic signed [24:0]        nm1_s;
    logic signed [60:0]        mul2_next;
    logic                      div_start;
    logic signed [DIVD_W-1:0]  div_dividend;
    logic signed [DIVS_W-1:0]  div_divisor;
    logic                      div_done;
    logic signed [DIVD_W-1:0]  quot;
    logic [STAT_W+32:0]        sum_next;
    logic [STAT_W-1:0]         sat_next;
    logic [COUNT_W-1:0]        n_next;

    always_comb begin
        addr      = CW'(CW'(p_idx) * CW'(MAX_ACTIONS)) + CW'(a_idx);
        x_sel     = cmd.is_action ? a_samp_reg[a_idx] : p_samp_reg[p_idx];
        mean_sel  = cmd.is_action ? a_mean_reg[a_idx] : p_mean_reg[p_idx];
        var_sel   = p_var_reg[p_idx];
        d_next    = {x_sel[VALUE_W-1], x_sel, 16'b0} - {mean_sel[STAT_W-1], mean_sel};
        opa       = dx_reg[p_idx];
        opb       = cmd.is_var ? dx_reg[p_idx] : dy_reg[a_idx];
        prod_next = opa * opb;
        p36       = prod_reg[61:26];
        nm1_s     = $signed({1'b0, nm1_reg});
        mul2_next = p36 * nm1_s;
        sum_next  = {quot[DIVD_W-1], quot} + {{33{old_reg[STAT_W-1]}}, old_reg};
        sat_next  = sat32(sum_next);
        n_next    = (n_reg == COUNT_MAX) ? n_reg : n_reg + 1'b1;
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = acc_reg;
        div_divisor  = {9'b0, n_reg};
        case (cmd.op)
            DP_MDIV, DP_DIV2: begin
                div_start = 1'b1;
            end
            DP_DIV1: begin
                div_start    = 1'b1;
                div_dividend = {{3{mul2_reg[60]}}, mul2_reg};
            end
            DP_QDIV: begin
                div_start    = var_sel != '0;
                div_dividend = {{16{rdata_reg[STAT_W-1]}}, rdata_reg, 16'b0};
                div_divisor  = {var_sel[STAT_W-1], var_sel};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    ocr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg   <= '0;
            nm1_reg <= '0;
            for (int i = 0; i < MAX_PERCEPTS; i++) begin
                p_samp_reg[i] <= '0;
                p_mean_reg[i] <= '0;
                p_var_reg[i]  <= '0;
            end
            for (int j = 0; j < MAX_ACTIONS; j++) begin
                a_samp_reg[j] <= '0;
                a_mean_reg[j] <= '0;
            end
        end else begin
            case (cmd.op)
                DP_WR: begin
                    if (cmd.is_action) begin
                        a_samp_reg[a_idx] <= cmd.value;
                    end else begin
                        p_samp_reg[p_idx] <= cmd.value;
                    end
                end
                DP_CNT: begin
                    n_reg   <= n_next;
                    nm1_reg <= n_next - 1'b1;
                end
                DP_MWR: begin
                    if (cmd.is_action) begin
                        a_mean_reg[a_idx] <= sat_next;
                    end else begin
                        p_mean_reg[p_idx] <= sat_next;
                    end
                end
                DP_SWR: begin
                    if (cmd.is_var) begin
                        p_var_reg[p_idx] <= sat_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_MDELTA: begin
                acc_reg <= {{31{d_next[32]}}, d_next};
                old_reg <= mean_sel;
                if (cmd.is_action) begin
                    dy_reg[a_idx] <= d_next[32:2];
                end else begin
                    dx_reg[p_idx] <= d_next[32:2];
                end
            end
            DP_MUL1: begin
                prod_reg <= prod_next;
                old_reg  <= cmd.is_var ? var_sel : rdata_reg;
            end
            DP_MUL2: begin
                mul2_reg <= mul2_next;
            end
            DP_SUB: begin
                acc_reg <= quot - {{32{old_reg[STAT_W-1]}}, old_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_CLR) begin
            cov_mem[addr] <= '0;
        end else if (cmd.op == DP_SWR && !cmd.is_var) begin
            cov_mem[addr] <= sat_next;
        end
        rdata_reg <= cov_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == DP_QOUT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_QOUT) begin
            coef_reg <= (var_sel == '0) ? '0 : sat24(quot);
            pos_reg  <= cmd.position;
            last_reg <= cmd.last;
        end
    end

    assign sts.div_done = div_done;
    assign sts.out_busy = m_tvalid_reg && !m_tready;
    assign sts.var_zero = var_sel == '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_coef   = coef_reg;
    assign m_pos    = pos_reg;
    assign m_last   = last_reg;

endmodule

@@ rtl/ocr_ctrl.sv @@
// Controller: configuration registers, input handshake and the sequencer that
// walks the update and query loops. Depends on ocr_pkg.
module ocr_ctrl
    import ocr_pkg::*;
#(
    parameter int MAX_PERCEPTS = 32,
    parameter int MAX_ACTIONS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  func_t                 s_func,
    input  logic [INDEX_W-1:0]    s_index,
    input  logic [VALUE_W-1:0]    s_value,
    input  logic                  s_end,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dp_cmd_t               cmd,
    output logic [(MAX_PERCEPTS > 1 ? $clog2(MAX_PERCEPTS) : 1)-1:0] p_idx,
    output logic [(MAX_ACTIONS > 1 ? $clog2(MAX_ACTIONS) : 1)-1:0]   a_idx,
    input  dp_sts_t               sts
);

    localparam int PW   = MAX_PERCEPTS > 1 ? $clog2(MAX_PERCEPTS) : 1;
    localparam int AW   = MAX_ACTIONS > 1 ? $clog2(MAX_ACTIONS) : 1;
    localparam int PCW  = $clog2(MAX_PERCEPTS + 1);
    localparam int ACW  = $clog2(MAX_ACTIONS + 1);
    localparam int PLIM = MAX_PERCEPTS < RESULT_CAP ? MAX_PERCEPTS : RESULT_CAP;
    localparam int ALIM = MAX_ACTIONS < RESULT_CAP ? MAX_ACTIONS : RESULT_CAP;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT,
        S_MEAN_D,
        S_MEAN_DIV,
        S_MEAN_WAIT,
        S_MEAN_WR,
        S_ST_RD,
        S_ST_MUL1,
        S_ST_MUL2,
        S_ST_DIV1,
        S_ST_W1,
        S_ST_SUB,
        S_ST_DIV2,
        S_ST_W2,
        S_ST_WR,
        S_Q_RD,
        S_Q_DIV,
        S_Q_WAIT,
        S_Q_OUT
    } state_t;

    state_t              state_reg;
    logic [PCW-1:0]      pc_reg;
    logic [ACW-1:0]      ac_reg;
    logic [PCNT_W-1:0]   pcount_reg;
    logic [ACNT_W-1:0]   acount_reg;
    logic [INDEX_W-1:0]  qidx_reg;
    logic                qcol_reg;
    logic                act_phase_reg;
    logic                var_phase_reg;

    logic [PCNT_W-1:0] np;
    logic [PCNT_W-1:0] na;
    logic              p_last;
    logic              a_last;
    logic              accept;

    always_comb begin
        if (pcount_reg == '0) begin
            np = PCNT_W'(1);
        end else if (32'(pcount_reg) > PLIM) begin
            np = PCNT_W'(PLIM);
        end else begin
            np = pcount_reg;
        end
        if (acount_reg == '0) begin
            na = PCNT_W'(1);
        end else if (32'(acount_reg) > ALIM) begin
            na = PCNT_W'(ALIM);
        end else begin
            na = {1'b0, acount_reg};
        end
        p_last   = 32'(pc_reg) + 32'd1 == 32'(np);
        a_last   = 32'(ac_reg) + 32'd1 == 32'(na);
        s_tready = state_reg == S_IDLE;
        accept   = s_tvalid && s_tready;
    end

    always_comb begin
        cmd.op        = DP_NOP;
        cmd.is_action = act_phase_reg;
        cmd.is_var    = var_phase_reg;
        cmd.last      = qcol_reg ? p_last : a_last;
        cmd.position  = qcol_reg ? POS_W'(pc_reg) : POS_W'(ac_reg);
        cmd.value     = s_value;
        p_idx         = PW'(pc_reg);
        a_idx         = AW'(ac_reg);
        unique case (state_reg)
            S_CLEAR:   cmd.op = DP_CLR;
            S_IDLE: begin
                p_idx         = PW'(s_index);
                a_idx         = AW'(s_index);
                cmd.is_action = s_func == FUNC_WR_ACTION;
                if (accept && s_func == FUNC_WR_PERCEPT && 32'(s_index) < MAX_PERCEPTS) begin
                    cmd.op = DP_WR;
                end
                if (accept && s_func == FUNC_WR_ACTION && 32'(s_index) < MAX_ACTIONS) begin
                    cmd.op = DP_WR;
                end
            end
            S_CNT:       cmd.op = DP_CNT;
            S_MEAN_D:    cmd.op = DP_MDELTA;
            S_MEAN_DIV:  cmd.op = DP_MDIV;
            S_MEAN_WAIT: cmd.op = DP_NOP;
            S_MEAN_WR:   cmd.op = DP_MWR;
            S_ST_RD:     cmd.op = DP_NOP;
            S_ST_MUL1:   cmd.op = DP_MUL1;
            S_ST_MUL2:   cmd.op = DP_MUL2;
            S_ST_DIV1:   cmd.op = DP_DIV1;
            S_ST_W1:     cmd.op = DP_NOP;
            S_ST_SUB:    cmd.op = DP_SUB;
            S_ST_DIV2:   cmd.op = DP_DIV2;
            S_ST_W2:     cmd.op = DP_NOP;
            S_ST_WR:     cmd.op = DP_SWR;
            S_Q_RD, S_Q_DIV, S_Q_WAIT, S_Q_OUT: begin
                p_idx = qcol_reg ? PW'(pc_reg) : PW'(qidx_reg);
                a_idx = qcol_reg ? AW'(qidx_reg) : AW'(ac_reg);
                if (state_reg == S_Q_DIV) begin
                    cmd.op = DP_QDIV;
                end else if (state_reg == S_Q_OUT && !sts.out_busy) begin
                    cmd.op = DP_QOUT;
                end
            end
            default:     cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            pc_reg        <= '0;
            ac_reg        <= '0;
            pcount_reg    <= PCNT_RESET;
            acount_reg    <= ACNT_RESET;
            qidx_reg      <= '0;
            qcol_reg      <= 1'b0;
            act_phase_reg <= 1'b0;
            var_phase_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PERCEPT_COUNT: pcount_reg <= cfg_data;
                    CFG_ACTION_COUNT:  acount_reg <= cfg_data[ACNT_W-1:0];
                    default:           pcount_reg <= pcount_reg;
                endcase
            end
            unique case (state_reg)
                S_CLEAR: begin
                    if (32'(ac_reg) == MAX_ACTIONS - 1) begin
                        ac_reg <= '0;
                        if (32'(pc_reg) == MAX_PERCEPTS - 1) begin
                            pc_reg    <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            pc_reg <= pc_reg + 1'b1;
                        end
                    end else begin
                        ac_reg <= ac_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    pc_reg <= '0;
                    ac_reg <= '0;
                    if (accept) begin
                        qidx_reg <= s_index;
                        unique case (s_func)
                            FUNC_WR_PERCEPT: state_reg <= S_IDLE;
                            FUNC_WR_ACTION: begin
                                if (s_end) begin
                                    state_reg <= S_CNT;
                                end
                            end
                            FUNC_Q_ROW: begin
                                qcol_reg <= 1'b0;
                                if (32'(s_index) < 32'(np)) begin
                                    state_reg <= S_Q_RD;
                                end
                            end
                            FUNC_Q_COL: begin
                                qcol_reg <= 1'b1;
                                if (32'(s_index) < 32'(na)) begin
                                    state_reg <= S_Q_RD;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CNT: begin
                    act_phase_reg <= 1'b0;
                    state_reg     <= S_MEAN_D;
                end
                S_MEAN_D:   state_reg <= S_MEAN_DIV;
                S_MEAN_DIV: state_reg <= S_MEAN_WAIT;
                S_MEAN_WAIT: begin
                    if (sts.div_done) begin
                        state_reg <= S_MEAN_WR;
                    end
                end
                S_MEAN_WR: begin
                    state_reg <= S_MEAN_D;
                    if (!act_phase_reg) begin
                        if (p_last) begin
                            pc_reg        <= '0;
                            act_phase_reg <= 1'b1;
                        end else begin
                            pc_reg <= pc_reg + 1'b1;
                        end
                    end else if (a_last) begin
                        ac_reg        <= '0;
                        pc_reg        <= '0;
                        act_phase_reg <= 1'b0;
                        var_phase_reg <= 1'b1;
                        state_reg     <= S_ST_RD;
                    end else begin
                        ac_reg <= ac_reg + 1'b1;
                    end
                end
                S_ST_RD:   state_reg <= S_ST_MUL1;
                S_ST_MUL1: state_reg <= S_ST_MUL2;
                S_ST_MUL2: state_reg <= S_ST_DIV1;
                S_ST_DIV1: state_reg <= S_ST_W1;
                S_ST_W1: begin
                    if (sts.div_done) begin
                        state_reg <= S_ST_SUB;
                    end
                end
                S_ST_SUB:  state_reg <= S_ST_DIV2;
                S_ST_DIV2: state_reg <= S_ST_W2;
                S_ST_W2: begin
                    if (sts.div_done) begin
                        state_reg <= S_ST_WR;
                    end
                end
                S_ST_WR: begin
                    state_reg <= S_ST_RD;
                    if (var_phase_reg) begin
                        var_phase_reg <= 1'b0;
                        ac_reg        <= '0;
                    end else if (a_last) begin
                        ac_reg <= '0;
                        if (p_last) begin
                            pc_reg    <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            pc_reg        <= pc_reg + 1'b1;
                            var_phase_reg <= 1'b1;
                        end
                    end else begin
                        ac_reg <= ac_reg + 1'b1;
                    end
                end
                S_Q_RD:  state_reg <= S_Q_DIV;
                S_Q_DIV: state_reg <= sts.var_zero ? S_Q_OUT : S_Q_WAIT;
                S_Q_WAIT: begin
                    if (sts.div_done) begin
                        state_reg <= S_Q_OUT;
                    end
                end
                S_Q_OUT: begin
                    if (!sts.out_busy) begin
                        state_reg <= S_Q_RD;
                        if (cmd.last) begin
                            pc_reg    <= '0;
                            ac_reg    <= '0;
                            state_reg <= S_IDLE;
                        end else if (qcol_reg) begin
                            pc_reg <= pc_reg + 1'b1;
                        end else begin
                            ac_reg <= ac_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_QOUT |-> !sts.out_busy)
        else $error("result loaded while previous transaction pending");
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == S_MEAN_WAIT || state_reg == S_ST_W1 ||
                          state_reg == S_ST_W2 || state_reg == S_Q_WAIT))
        else $error("quotient arrived outside a wait state");
    a_update_start: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CNT |=> state_reg == S_MEAN_D && pc_reg == '0 && ac_reg == '0)
        else $error("update did not start at element zero");

endmodule

@@ rtl/online_covariance_regression_top.sv @@
// Top level of the online covariance regression block.
// Depends on ocr_pkg, ocr_ctrl and ocr_datapath.
//
// Element writes can follow back to back. An action write with tlast set runs the statistics
// update, which walks the means and then the percept-by-action matrix through one shared
// restoring divider that produces a quotient bit per cycle. A query returns its coefficients
// one after another and skips the divide where the percept variance is zero. After reset
// the block clears its covariance memory before it takes the first transaction;
// configuration writes are taken at any time.
module online_covariance_regression_top
    import ocr_pkg::*;
#(
    parameter int MAX_PERCEPTS = 32,
    parameter int MAX_ACTIONS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // index[4:0], value[20:5], zero pad
    input  logic [1:0]            s_tuser,   // func[1:0]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // coefficient[23:0], position[28:24], zero pad
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = MAX_PERCEPTS > 1 ? $clog2(MAX_PERCEPTS) : 1;
    localparam int AW = MAX_ACTIONS > 1 ? $clog2(MAX_ACTIONS) : 1;

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [PW-1:0]     p_idx;
    logic [AW-1:0]     a_idx;
    logic [COEF_W-1:0] coef;
    logic [POS_W-1:0]  pos;

    assign cfg_ready = 1'b1;

    ocr_ctrl #(
        .MAX_PERCEPTS (MAX_PERCEPTS),
        .MAX_ACTIONS  (MAX_ACTIONS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_func    (func_t'(s_tuser)),
        .s_index   (s_tdata[4:0]),
        .s_value   (s_tdata[20:5]),
        .s_end     (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .p_idx     (p_idx),
        .a_idx     (a_idx),
        .sts       (sts)
    );

    ocr_datapath #(
        .MAX_PERCEPTS (MAX_PERCEPTS),
        .MAX_ACTIONS  (MAX_ACTIONS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .p_idx    (p_idx),
        .a_idx    (a_idx),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_coef   (coef),
        .m_pos    (pos),
        .m_last   (m_tlast)
    );

    assign m_tdata = {3'b0, pos, coef};

endmodule
